// ===== rtl/qtbe_pkg.sv =====
// Shared definitions for the quadtree bitmap encoder.
// Holds command codes, register indexes, fixed field widths and the
// status struct passed from the scan engine to the top level.
package qtbe_pkg;

  // Fixed widths of the channel fields and configuration registers.
  localparam int CMD_W     = 2;
  localparam int POS_W     = 8;
  localparam int REG_W     = 9;
  localparam int COUNT_W   = 17;
  localparam int LEN_W     = 4;
  localparam int DIG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Commands carried by the input channel.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // Status of one search for the next all-ones block.
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } qtbe_scan_sts_t;

endpackage

// ===== rtl/quadtree_bitmap_encoder.sv =====
// Top level of the quadtree bitmap encoder: command sequencer, registers
// and output stage. Uses qtbe_pkg, qtbe_bitmap and qtbe_scan.
//
// Usage: the input channel carries commands (write pixel, finish, read next
// code) with valid/ready; each command produces exactly one result transfer
// on the output channel. Image rows and columns are set through the plain
// write port by the user while the block is idle; the block does not check it.
// A pixel write or an unknown command moves from the idle state to the push
// state and from there into the output register. Finish and read run a
// search that visits image cells in Z order, reading and then evaluating
// each cell visited; a finish starts the search anew after each block found
// and visits every cell of the padded square at least once, a read visits
// cells from the current scan position up to the code after the one it
// returns. The search walks cell by cell over the single read port of the image store.
// One command is in work at a time; the next transfer is taken once the
// result sits in the output register, even if the receiver has not yet
// taken it. A stalled receiver holds the result and, behind it, at most
// one more finished result before the input stops.
// Reset: after reset the image store is cleared, one entry per cycle,
// over all MAX_SIDE*MAX_SIDE entries (65536 by default); the input is not
// ready during that pass, while configuration writes are taken.
module quadtree_bitmap_encoder #(
  parameter int MAX_SIDE = 256,
  parameter int LOG_SIDE = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [qtbe_pkg::CMD_W-1:0]         in_command,
  input  logic [qtbe_pkg::POS_W-1:0]         in_row,
  input  logic [qtbe_pkg::POS_W-1:0]         in_col,
  input  logic                               in_pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [qtbe_pkg::COUNT_W-1:0]       out_code_count,
  output logic                               out_code_valid,
  output logic [qtbe_pkg::LEN_W-1:0]         out_code_length,
  output logic [qtbe_pkg::DIG_W-1:0]         out_code_digits,
  output logic                               out_last_code,
  input  logic                               cfg_we,
  input  logic [qtbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qtbe_pkg::REG_W-1:0]         cfg_wdata
);

  import qtbe_pkg::*;

  localparam int ZW    = 2 * LOG_SIDE + 1;
  localparam int KW    = (LOG_SIDE > 0) ? $clog2(LOG_SIDE + 1) : 1;
  localparam int SIDEW = $clog2(MAX_SIDE + 1);
  localparam int CLW   = (SIDEW > 9) ? SIDEW : 9;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (ZW > DIG_W) ? ZW : DIG_W;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_FIN  = 3'd1;
  localparam logic [2:0] T_RD1  = 3'd2;
  localparam logic [2:0] T_RD2  = 3'd3;
  localparam logic [2:0] T_PUSH = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [REG_W-1:0]   image_rows_r;
  logic [REG_W-1:0]   image_cols_r;
  logic [KW-1:0]      lv_r, lv_nxt;
  logic [ZW-1:0]      codes_found_r, codes_found_nxt;
  logic [ZW-1:0]      n_r, n_nxt;
  logic [ZW-1:0]      scan_position_r, scan_position_nxt;
  logic               start_r, start_nxt;
  logic [ZW-1:0]      start_pos_r, start_pos_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [LEN_W-1:0]   res_len_r, res_len_nxt;
  logic [DIG_W-1:0]   res_digits_r, res_digits_nxt;
  logic               res_last_r, res_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_cvalid_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [DIG_W-1:0]   out_digits_r;
  logic               out_last_r;
  logic               out_load;

  logic [CLW-1:0]     rows_lim;
  logic [CLW-1:0]     cols_lim;
  logic [CLW-1:0]     need;
  logic [KW-1:0]      lv_cfg;
  logic [ZW-1:0]      total_cfg;
  logic [ZW-1:0]      total_r;
  logic [5:0]         dig_shamt;
  logic [DIG_W-1:0]   digits;
  logic               in_fire;
  logic               mem_wr;
  logic [AW-1:0]      mem_wr_addr;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic               mem_rd_data;
  logic               mem_busy;

  qtbe_scan_sts_t     sts;
  logic [ZW-1:0]      scan_pos;
  logic [KW-1:0]      scan_k;
  logic [ZW-1:0]      scan_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r <= REG_W'(256);
      image_cols_r <= REG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: image_rows_r <= cfg_wdata;
        CFG_COLS: image_cols_r <= cfg_wdata;
        default: begin
          image_rows_r <= image_rows_r;
        end
      endcase
    end
  end

  // Used area, saturated to the store side, and the level of the padded square.
  assign rows_lim = (CLW'(image_rows_r) > CLW'(MAX_SIDE)) ? CLW'(MAX_SIDE) : CLW'(image_rows_r);
  assign cols_lim = (CLW'(image_cols_r) > CLW'(MAX_SIDE)) ? CLW'(MAX_SIDE) : CLW'(image_cols_r);
  assign need     = (rows_lim > cols_lim) ? rows_lim : cols_lim;

  always_comb begin
    lv_cfg = KW'(LOG_SIDE);
    for (int l = LOG_SIDE - 1; l >= 0; l--) begin
      if (32'(need) <= (32'd1 << l)) begin
        lv_cfg = KW'(l);
      end
    end
  end

  assign total_cfg = ZW'(1) << {lv_cfg, 1'b0};
  assign total_r   = ZW'(1) << {lv_r, 1'b0};

  // Path digits: the block's Z index moved up so the first digit is on top.
  assign dig_shamt = 6'(2 * LOG_SIDE) - 6'({lv_r, 1'b0});
  assign digits    = DIG_W'(SW'(scan_pos) << dig_shamt);

  assign in_ready = (state_r == T_IDLE) && !mem_busy;
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == T_PUSH) && (!out_valid_r || out_ready);

  // Pixel writes go straight to the store on the transfer.
  assign mem_wr = in_fire && (in_command == CMD_WRITE) &&
                  (int'(in_row) < MAX_SIDE) && (int'(in_col) < MAX_SIDE);
  assign mem_wr_addr = AW'(in_row) * AW'(MAX_SIDE) + AW'(in_col);

  // Command sequencer.
  always_comb begin
    state_nxt         = state_r;
    lv_nxt            = lv_r;
    codes_found_nxt   = codes_found_r;
    n_nxt             = n_r;
    scan_position_nxt = scan_position_r;
    start_nxt         = 1'b0;
    start_pos_nxt     = start_pos_r;
    res_valid_nxt     = res_valid_r;
    res_len_nxt       = res_len_r;
    res_digits_nxt    = res_digits_r;
    res_last_nxt      = res_last_r;
    case (state_r)
      T_IDLE: begin
        if (in_fire) begin
          lv_nxt         = lv_cfg;
          res_valid_nxt  = 1'b0;
          res_len_nxt    = '0;
          res_digits_nxt = '0;
          res_last_nxt   = 1'b0;
          case (in_command)
            CMD_FINISH: begin
              n_nxt         = '0;
              start_nxt     = 1'b1;
              start_pos_nxt = '0;
              state_nxt     = T_FIN;
            end
            CMD_READ: begin
              start_nxt     = 1'b1;
              start_pos_nxt = (scan_position_r < total_cfg) ? scan_position_r : total_cfg;
              state_nxt     = T_RD1;
            end
            default: begin
              state_nxt = T_PUSH;
            end
          endcase
        end
      end
      T_FIN: begin
        if (sts.done) begin
          if (sts.found) begin
            n_nxt         = n_r + ZW'(1);
            start_nxt     = 1'b1;
            start_pos_nxt = scan_next;
          end else begin
            codes_found_nxt   = n_r;
            scan_position_nxt = '0;
            state_nxt         = T_PUSH;
          end
        end
      end
      T_RD1: begin
        if (sts.done) begin
          if (sts.found) begin
            res_valid_nxt     = 1'b1;
            res_len_nxt       = LEN_W'(lv_r) - LEN_W'(scan_k);
            res_digits_nxt    = digits;
            scan_position_nxt = scan_next;
            start_nxt         = 1'b1;
            start_pos_nxt     = scan_next;
            state_nxt         = T_RD2;
          end else begin
            scan_position_nxt = total_r;
            state_nxt         = T_PUSH;
          end
        end
      end
      T_RD2: begin
        if (sts.done) begin
          res_last_nxt = !sts.found;
          state_nxt    = T_PUSH;
        end
      end
      T_PUSH: begin
        if (out_load) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // Output register flag: set on load, cleared when the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= T_IDLE;
      start_r         <= 1'b0;
      out_valid_r     <= 1'b0;
      codes_found_r   <= '0;
      scan_position_r <= '0;
    end else begin
      state_r         <= state_nxt;
      start_r         <= start_nxt;
      out_valid_r     <= out_valid_nxt;
      codes_found_r   <= codes_found_nxt;
      scan_position_r <= scan_position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r         <= lv_nxt;
    n_r          <= n_nxt;
    start_pos_r  <= start_pos_nxt;
    res_valid_r  <= res_valid_nxt;
    res_len_r    <= res_len_nxt;
    res_digits_r <= res_digits_nxt;
    res_last_r   <= res_last_nxt;
    if (out_load) begin
      out_count_r  <= COUNT_W'(codes_found_r);
      out_cvalid_r <= res_valid_r;
      out_len_r    <= res_len_r;
      out_digits_r <= res_digits_r;
      out_last_r   <= res_last_r;
    end
  end

  qtbe_bitmap #(
    .MAX_SIDE (MAX_SIDE)
  ) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (in_pixel),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  qtbe_scan #(
    .MAX_SIDE (MAX_SIDE),
    .LOG_SIDE (LOG_SIDE)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .start_pos (start_pos_r),
    .lv        (lv_r),
    .rows_lim  (rows_lim),
    .cols_lim  (cols_lim),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data   (mem_rd_data),
    .sts       (sts),
    .res_pos   (scan_pos),
    .res_k     (scan_k),
    .res_next  (scan_next)
  );

  assign out_valid       = out_valid_r;
  assign out_code_count  = out_count_r;
  assign out_code_valid  = out_cvalid_r;
  assign out_code_length = out_len_r;
  assign out_code_digits = out_digits_r;
  assign out_last_code   = out_last_r;

  // No pixel write may land while the clearing pass still owns the store.
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> !mem_busy)
    else $error("pixel write during clearing pass");

  // A new command is only taken when the search engine is idle.
  a_ready_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.busy)
    else $error("input ready while search is running");

  // Search results arrive only while the sequencer waits for them.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == T_FIN || state_r == T_RD1 || state_r == T_RD2))
    else $error("search finished outside a waiting state");

  // The final-code flag only comes with a returned code.
  a_last_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_code) |-> out_code_valid)
    else $error("last code flagged without a code");

endmodule

// ===== rtl/qtbe_bitmap.sv =====
// Single-bit image store with a clearing pass after reset.
// One write port and one registered read port; no package dependency.
module qtbe_bitmap #(
  parameter int MAX_SIDE = 256,
  parameter int DEPTH    = MAX_SIDE * MAX_SIDE,
  parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  output logic          busy
);

  logic          mem [DEPTH];
  logic          rd_data_r;
  logic          clr_busy_r;
  logic          clr_busy_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;

  // The clearing pass walks every entry once, one per cycle.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Storage: the clearing pass has priority over pixel writes.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// ===== rtl/qtbe_scan.sv =====
// Search engine that finds the next maximal all-ones block in Z order.
// Reads the image store one cell at a time; uses qtbe_pkg for its status.
module qtbe_scan #(
  parameter int MAX_SIDE = 256,
  parameter int LOG_SIDE = 8,
  parameter int ZW       = 2 * LOG_SIDE + 1,
  parameter int KW       = (LOG_SIDE > 0) ? $clog2(LOG_SIDE + 1) : 1,
  parameter int SIDEW    = $clog2(MAX_SIDE + 1),
  parameter int CLW      = (SIDEW > 9) ? SIDEW : 9,
  parameter int DEPTH    = MAX_SIDE * MAX_SIDE,
  parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ZW-1:0]            start_pos,
  input  logic [KW-1:0]            lv,
  input  logic [CLW-1:0]           rows_lim,
  input  logic [CLW-1:0]           cols_lim,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic                     rd_data,
  output qtbe_pkg::qtbe_scan_sts_t sts,
  output logic [ZW-1:0]            res_pos,
  output logic [KW-1:0]            res_k,
  output logic [ZW-1:0]            res_next
);

  import qtbe_pkg::*;

  localparam int RW  = (LOG_SIDE > 0) ? LOG_SIDE : 1;
  localparam int CMW = (RW > CLW) ? RW : CLW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [ZW-1:0] cur_r, cur_nxt;
  logic [ZW-1:0] pos_r, pos_nxt;
  logic [ZW-1:0] mask_r, mask_nxt;
  logic [KW-1:0] amax_r, amax_nxt;
  logic [KW-1:0] lv_r, lv_nxt;
  logic          run_r, run_nxt;
  logic          inr_r, inr_nxt;
  logic          found_r, found_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [ZW-1:0] next_r, next_nxt;

  logic [ZW-1:0] total;
  logic [ZW-1:0] cur_inc;
  logic [RW-1:0] cell_row;
  logic [RW-1:0] cell_col;
  logic          in_range;
  logic          cell_bit;
  logic [ZW-1:0] first_mask;
  logic [KW-1:0] first_amax;
  logic [KW-1:0] brk_k;
  logic [ZW-1:0] brk_off;

  assign total   = ZW'(1) << {lv_r, 1'b0};
  // The one incrementer steps the scan through the Z order.
  assign cur_inc = cur_r + ZW'(1);
  assign cell_bit = rd_data & inr_r;

  // Split the Z index into row (odd bits) and column (even bits).
  always_comb begin
    cell_row = '0;
    cell_col = '0;
    for (int b = 0; b < LOG_SIDE; b++) begin
      cell_col[b] = cur_r[2*b];
      cell_row[b] = cur_r[2*b+1];
    end
  end

  assign in_range = (CMW'(cell_row) < CMW'(rows_lim)) && (CMW'(cell_col) < CMW'(cols_lim));

  // Largest aligned block a set cell may start, limited by the square.
  always_comb begin
    logic [ZW-1:0] lm;
    first_mask = '0;
    first_amax = '0;
    for (int a = 1; a <= LOG_SIDE; a++) begin
      lm = (ZW'(1) << (2 * a)) - ZW'(1);
      if ((KW'(a) <= lv_r) && ((cur_r & lm) == '0)) begin
        first_mask = lm;
        first_amax = KW'(a);
      end
    end
  end

  // When a run of ones breaks, the block level is the top nonzero digit of its length.
  assign brk_off = cur_r & mask_r;
  always_comb begin
    brk_k = '0;
    for (int a = 1; a < LOG_SIDE; a++) begin
      if (brk_off[2*a +: 2] != 2'b00) begin
        brk_k = KW'(a);
      end
    end
  end

  // Sequencer: issue a read, evaluate the cell, repeat.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    mask_nxt  = mask_r;
    amax_nxt  = amax_r;
    lv_nxt    = lv_r;
    run_nxt   = run_r;
    inr_nxt   = inr_r;
    found_nxt = found_r;
    done_nxt  = 1'b0;
    k_nxt     = k_r;
    next_nxt  = next_r;
    rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cur_nxt   = start_pos;
          lv_nxt    = lv;
          run_nxt   = 1'b0;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (cur_r >= total) begin
          found_nxt = 1'b0;
          pos_nxt   = total;
          k_nxt     = '0;
          next_nxt  = total;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          inr_nxt   = in_range;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (!run_r) begin
          if (!cell_bit) begin
            cur_nxt   = cur_inc;
            state_nxt = S_ADDR;
          end else begin
            pos_nxt = cur_r;
            if ((cur_inc & first_mask) == '0) begin
              // The set cell cannot start a larger block.
              found_nxt = 1'b1;
              k_nxt     = first_amax;
              next_nxt  = cur_inc;
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              run_nxt   = 1'b1;
              mask_nxt  = first_mask;
              amax_nxt  = first_amax;
              cur_nxt   = cur_inc;
              state_nxt = S_ADDR;
            end
          end
        end else begin
          if (cell_bit && ((cur_inc & mask_r) == '0)) begin
            // The whole aligned block is set.
            found_nxt = 1'b1;
            k_nxt     = amax_r;
            next_nxt  = cur_inc;
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (cell_bit) begin
            cur_nxt   = cur_inc;
            state_nxt = S_ADDR;
          end else begin
            found_nxt = 1'b1;
            k_nxt     = brk_k;
            next_nxt  = pos_r | (ZW'(1) << {brk_k, 1'b0});
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    pos_r   <= pos_nxt;
    mask_r  <= mask_nxt;
    amax_r  <= amax_nxt;
    lv_r    <= lv_nxt;
    inr_r   <= inr_nxt;
    found_r <= found_nxt;
    k_r     <= k_nxt;
    next_r  <= next_nxt;
  end

  // Cell address in the row-major store.
  assign rd_addr = AW'(cell_row) * AW'(MAX_SIDE) + AW'(cell_col);

  assign sts.busy  = (state_r != S_IDLE);
  assign sts.done  = done_r;
  assign sts.found = found_r;
  assign res_pos   = pos_r;
  assign res_k     = k_r;
  assign res_next  = next_r;

endmodule
